### rtl/sssc_pkg.sv
// Package for the seven-segment scan capture block.
// Holds the digit count default, the warm-up limit and the segment decoder.
// No dependencies.
package sssc_pkg;

	localparam int DIGITS_DEF = 8;
	localparam int MAX_DIGITS = 8;
	localparam int LAST_W = 4;
	localparam int WARM_W = 4;
	localparam int NIB_W = 4;
	localparam int SEG_W = 8;
	localparam int DISP_W = MAX_DIGITS * NIB_W;

	localparam logic [LAST_W-1:0] NO_DIGIT = 4'hF;
	localparam logic [WARM_W-1:0] WARMUP_FULL = 4'd8;
	localparam logic [SEG_W-1:0] SEG_RESET = 8'hFF;

	// Active-low segment codes, bit 0 is segment a, bit 6 is segment g
	localparam logic [SEG_W-1:0] SEG_0 = 8'h40;
	localparam logic [SEG_W-1:0] SEG_1 = 8'h79;
	localparam logic [SEG_W-1:0] SEG_2 = 8'h24;
	localparam logic [SEG_W-1:0] SEG_3 = 8'h30;
	localparam logic [SEG_W-1:0] SEG_4 = 8'h19;
	localparam logic [SEG_W-1:0] SEG_5 = 8'h12;
	localparam logic [SEG_W-1:0] SEG_6 = 8'h02;
	localparam logic [SEG_W-1:0] SEG_7 = 8'h78;
	localparam logic [SEG_W-1:0] SEG_8 = 8'h00;
	localparam logic [SEG_W-1:0] SEG_9 = 8'h18;
	localparam logic [SEG_W-1:0] SEG_A = 8'h08;
	localparam logic [SEG_W-1:0] SEG_B = 8'h03;
	localparam logic [SEG_W-1:0] SEG_C = 8'h46;
	localparam logic [SEG_W-1:0] SEG_D = 8'h21;
	localparam logic [SEG_W-1:0] SEG_E = 8'h06;
	localparam logic [SEG_W-1:0] SEG_F = 8'h0E;

	// Unknown patterns decode to zero
	function automatic logic [NIB_W-1:0] decode_seg(input logic [SEG_W-1:0] p);
		logic [NIB_W-1:0] n;
		case (p)
			SEG_0: n = 4'h0;
			SEG_1: n = 4'h1;
			SEG_2: n = 4'h2;
			SEG_3: n = 4'h3;
			SEG_4: n = 4'h4;
			SEG_5: n = 4'h5;
			SEG_6: n = 4'h6;
			SEG_7: n = 4'h7;
			SEG_8: n = 4'h8;
			SEG_9: n = 4'h9;
			SEG_A: n = 4'hA;
			SEG_B: n = 4'hB;
			SEG_C: n = 4'hC;
			SEG_D: n = 4'hD;
			SEG_E: n = 4'hE;
			SEG_F: n = 4'hF;
			default: n = 4'h0;
		endcase
		return n;
	endfunction

endpackage

### rtl/seven_segment_scan_capture_top.sv
// Seven-segment scan capture, top level.
// Captures per-digit segment patterns from a scanned display and decodes them.
// Depends on sssc_pkg.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_ready, anode_lines,      | sink
//          | cathode_lines                         |
//  out     | out_valid, out_ready, updated,        | source
//          | display_value                         |
//
// One item per cycle unless a held result stalls the input; each result appears in the cycle after its item is taken.
// Capture state updates at the accept edge, the decoded result goes to an
// output register. A held result stalls the input only while out_ready is low.
// Reset restores all patterns to segments-off, no digit seen, warm-up zero.
module seven_segment_scan_capture_top #(
	parameter int DIGITS = sssc_pkg::DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sssc_pkg::SEG_W-1:0]    anode_lines,
	input  logic [sssc_pkg::SEG_W-1:0]    cathode_lines,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          updated,
	output logic [sssc_pkg::DISP_W-1:0]   display_value
);
	import sssc_pkg::*;

	logic [SEG_W-1:0]  pat_q [DIGITS];
	logic [SEG_W-1:0]  pat_d [DIGITS];
	logic [LAST_W-1:0] last_q;
	logic [WARM_W-1:0] warm_q;
	logic [WARM_W-1:0] warm_d;
	logic [LAST_W-1:0] active;
	logic              capture;
	logic              changed;
	logic              upd_d;
	logic [DISP_W-1:0] disp_d;
	logic              out_valid_q;
	logic              upd_q;
	logic [DISP_W-1:0] disp_q;
	logic              accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	// Highest-numbered low anode bit wins
	always_comb begin
		active = NO_DIGIT;
		for (int i = 0; i < DIGITS; i++) begin
			if (!anode_lines[i]) begin
				active = LAST_W'(i);
			end
		end
	end

	assign capture = (active != NO_DIGIT) && (active != last_q);

	always_comb begin
		changed = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			pat_d[i] = pat_q[i];
			if (capture && (active == LAST_W'(i)) && (pat_q[i] != cathode_lines)) begin
				pat_d[i] = cathode_lines;
				changed = 1'b1;
			end
		end
		warm_d = warm_q;
		if (changed && (warm_q < WARMUP_FULL)) begin
			warm_d = warm_q + 1'b1;
		end
		upd_d = changed && (warm_d >= WARMUP_FULL);
	end

	always_comb begin
		disp_d = '0;
		for (int i = 0; i < DIGITS; i++) begin
			disp_d[i*NIB_W +: NIB_W] = decode_seg(pat_d[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				pat_q[i] <= SEG_RESET;
			end
			last_q <= NO_DIGIT;
			warm_q <= '0;
		end else if (accept) begin
			pat_q <= pat_d;
			if (capture) begin
				last_q <= active;
			end
			warm_q <= warm_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload loads only with a new item, holds while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			upd_q <= upd_d;
			disp_q <= disp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign updated = upd_q;
	assign display_value = disp_q;

endmodule

### tb/tb.sv
// Testbench for the seven-segment scan capture block.
// It drives scanned anode/cathode items and checks each result against its own scan tracker.
// It depends on sssc_pkg and seven_segment_scan_capture_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sssc_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int SHOW_LIMIT = 10;
	// All sixteen glyph codes, digit value n at bits n*8 +: 8
	localparam logic [16*SEG_W-1:0] GLYPHS = {SEG_F, SEG_E, SEG_D, SEG_C, SEG_B, SEG_A,
		SEG_9, SEG_8, SEG_7, SEG_6, SEG_5, SEG_4, SEG_3, SEG_2, SEG_1, SEG_0};

	typedef struct packed {
		logic              upd;
		logic [DISP_W-1:0] disp;
	} scan_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [SEG_W-1:0]  anode_lines = '1;
	logic [SEG_W-1:0]  cathode_lines = '1;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              updated;
	logic [DISP_W-1:0] display_value;

	// Tracked display state
	logic [SEG_W-1:0]  seg_store [MAX_DIGITS];
	logic [LAST_W-1:0] last_seen;
	logic [WARM_W-1:0] warm_cnt;

	scan_result_t      expected_scans [$];
	scan_result_t      head;
	int                send_gap_pct = 0;
	int                recv_gap_pct = 0;
	int                hold_left = 0;
	int                cycles = 0;
	int                items_sent = 0;
	int                results_seen = 0;
	int                updates_seen = 0;
	int                errors = 0;

	seven_segment_scan_capture_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.anode_lines   (anode_lines),
		.cathode_lines (cathode_lines),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.updated       (updated),
		.display_value (display_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				expected_scans.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: long hold-off first, otherwise random stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	function automatic logic [NIB_W-1:0] glyph_value(input logic [SEG_W-1:0] pat);
		logic [NIB_W-1:0] v;
		v = '0;
		for (int n = 0; n < 16; n++)
			if (GLYPHS[n*SEG_W +: SEG_W] == pat)
				v = NIB_W'(n);
		return v;
	endfunction

	function automatic scan_result_t capture_scan(input logic [SEG_W-1:0] an,
			input logic [SEG_W-1:0] cat);
		scan_result_t r;
		logic [LAST_W-1:0] act;
		act = NO_DIGIT;
		r.upd = 1'b0;
		// highest low anode wins
		for (int d = 0; d < MAX_DIGITS; d++)
			if (!an[d])
				act = LAST_W'(d);
		if (act != NO_DIGIT && act != last_seen) begin
			last_seen = act;
			if (seg_store[act] != cat) begin
				seg_store[act] = cat;
				if (warm_cnt < WARMUP_FULL)
					warm_cnt = warm_cnt + 1'b1;
				r.upd = (warm_cnt >= WARMUP_FULL);
			end
		end
		r.disp = '0;
		for (int d = 0; d < MAX_DIGITS; d++)
			r.disp[d*NIB_W +: NIB_W] = glyph_value(seg_store[d]);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input scan_result_t want);
		errors++;
		if (errors <= SHOW_LIMIT)
			$display("%0d: %s: expected updated=%0b value=%h, got updated=%0b value=%h",
				cycles, what, want.upd, want.disp, updated, display_value);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (updated)
				updates_seen++;
			if (expected_scans.size() == 0) begin
				report_mismatch("result with nothing expected", '0);
			end else begin
				head = expected_scans.pop_front();
				if (updated !== head.upd || display_value !== head.disp)
					report_mismatch("mismatch", head);
			end
		end
	end

	task automatic send_item(input logic [SEG_W-1:0] an, input logic [SEG_W-1:0] cat);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		anode_lines <= an;
		cathode_lines <= cat;
		@(posedge clk);
		while (!(in_valid && in_ready))
			@(posedge clk);
		expected_scans.push_back(capture_scan(an, cat));
		items_sent++;
	endtask

	// Drop valid, then hold until every result is back
	task automatic pause_sender();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_scans.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [SEG_W-1:0] digit_anode(input int d);
		return ~(SEG_W'(1) << d);
	endfunction

	task automatic test_directed();
		send_item(8'hFF, 8'h00);              // no digit enabled
		send_item(8'h00, SEG_8);              // all anodes low picks digit 7
		send_item(8'h00, SEG_1);              // same digit again
		send_item(digit_anode(0), SEG_RESET); // same pattern as stored
		for (int d = 1; d <= MAX_DIGITS; d++)
			send_item(digit_anode(d % MAX_DIGITS), GLYPHS[(d % MAX_DIGITS)*SEG_W +: SEG_W]);
		for (int d = 1; d <= MAX_DIGITS; d++)
			send_item(digit_anode(d % MAX_DIGITS),
				GLYPHS[(8 + d % MAX_DIGITS)*SEG_W +: SEG_W]);
		send_item(digit_anode(3), 8'hA5);     // unknown pattern
		send_item(digit_anode(4), 8'hFF);
		send_item(8'h7F, 8'h00);              // bit 7 low, lower bits high
		pause_sender();
	endtask

	task automatic test_random_scan(input int n, input int sgap, input int rgap);
		int pos;
		int sel;
		logic [SEG_W-1:0] an;
		logic [SEG_W-1:0] cat;
		pos = 0;
		send_gap_pct = sgap;
		recv_gap_pct = rgap;
		repeat (n) begin
			sel = $urandom_range(99);
			if (sel < 75) begin
				// well-formed scan step, extra low bits below the active digit
				pos = ($urandom_range(9) == 0) ? $urandom_range(MAX_DIGITS-1)
					: (pos + 1) % MAX_DIGITS;
				an = digit_anode(pos) & ~(SEG_W'($urandom) & ((SEG_W'(1) << pos) - 1'b1));
				case ($urandom_range(9))
					0, 1, 2, 3, 4: cat = seg_store[pos];
					9: cat = SEG_W'($urandom);
					default: cat = GLYPHS[$urandom_range(15)*SEG_W +: SEG_W];
				endcase
			end else if (sel < 85) begin
				an = 8'hFF;
				cat = SEG_W'($urandom);
			end else begin
				an = SEG_W'($urandom);
				cat = SEG_W'($urandom);
			end
			send_item(an, cat);
		end
		pause_sender();
	endtask

	task automatic test_output_stall();
		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_left <= 80;
		for (int k = 0; k < 24; k++)
			send_item(digit_anode(k % MAX_DIGITS), GLYPHS[$urandom_range(15)*SEG_W +: SEG_W]);
		pause_sender();
	endtask

	task automatic test_drain_pause();
		send_gap_pct = 0;
		recv_gap_pct = 40;
		for (int k = 0; k < 10; k++)
			send_item(digit_anode(7 - k % MAX_DIGITS), SEG_W'($urandom));
		pause_sender();
		for (int k = 0; k < 10; k++)
			send_item(SEG_W'($urandom), GLYPHS[$urandom_range(15)*SEG_W +: SEG_W]);
		pause_sender();
	endtask

	initial begin
		for (int d = 0; d < MAX_DIGITS; d++)
			seg_store[d] = SEG_RESET;
		last_seen = NO_DIGIT;
		warm_cnt = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_scan(130, 17, 63);
		test_random_scan(130, 63, 17);
		test_random_scan(130, 0, 0);
		test_output_stall();
		test_drain_pause();

		repeat (4) @(posedge clk);
		if (expected_scans.size() != 0) begin
			$display("%0d results never arrived", expected_scans.size());
			errors += expected_scans.size();
		end
		$display("%0d scan items sent, %0d results checked, %0d with updated set",
			items_sent, results_seen, updates_seen);
		$display("covered directed glyphs, random scans under three stall mixes, %0d errors",
			errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
